[rtl/ithc_pkg.sv]
// shared types, codes and constants of the ipv4 transport header classifier
package ithc_pkg;

	// default depth of the frame record queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// link types
	localparam logic [1:0] LINK_ETH  = 2'd0;
	localparam logic [1:0] LINK_RAW  = 2'd1;
	localparam logic [1:0] LINK_NULL = 2'd2;
	localparam logic [1:0] LINK_SLL  = 2'd3;

	// ip header offsets per link type
	localparam logic [4:0] OFF_ETH  = 5'd14;
	localparam logic [4:0] OFF_VLAN = 5'd18;
	localparam logic [4:0] OFF_RAW  = 5'd0;
	localparam logic [4:0] OFF_NULL = 5'd4;
	localparam logic [4:0] OFF_SLL  = 5'd16;

	// ethernet type field positions and values
	localparam logic [6:0]  POS_ETYPE_HI = 7'd12;
	localparam logic [6:0]  POS_ETYPE_LO = 7'd13;
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [15:0] ETYPE_VLAN   = 16'h8100;

	// ip header byte positions relative to its start
	localparam logic [6:0] REL_IHL      = 7'd0;
	localparam logic [6:0] REL_TLEN_HI  = 7'd2;
	localparam logic [6:0] REL_TLEN_LO  = 7'd3;
	localparam logic [6:0] REL_FRAG_HI  = 7'd6;
	localparam logic [6:0] REL_FRAG_LO  = 7'd7;
	localparam logic [6:0] REL_PROTO    = 7'd9;
	localparam logic [6:0] REL_TCP_DOFF = 7'd12;

	// byte position saturates here
	localparam logic [6:0] POS_MAX = 7'd127;

	localparam logic [3:0] MIN_IHL = 4'd5;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
	localparam logic [7:0] ICMP_HDR_LEN = 8'd8;

	// verdict codes
	typedef enum logic [3:0] {
		V_TCP        = 4'd0,
		V_UDP        = 4'd1,
		V_ICMP       = 4'd2,
		V_OTHER_IP   = 4'd3,
		V_SHORT_ETH  = 4'd4,
		V_NON_IP     = 4'd5,
		V_FRAGMENT   = 4'd6,
		V_RSV_BIT    = 4'd7,
		V_BAD_IHL    = 4'd8,
		V_BAD_TCP_OFF = 4'd9,
		V_TCP_LEN    = 4'd10,
		V_UDP_LEN    = 4'd11,
		V_ICMP_LEN   = 4'd12,
		V_TRUNCATED  = 4'd13
	} verdict_t;

	// everything captured from one frame, handed from front to back
	typedef struct packed {
		logic        is_eth;
		logic [7:0]  frame_len;
		logic [4:0]  link_off;
		logic [15:0] ether_type;
		logic [3:0]  ip_words;
		logic [15:0] total_len;
		logic [15:0] frag_word;
		logic [7:0]  proto;
		logic [3:0]  tcp_words;
	} frame_rec_t;

endpackage

[rtl/ithc_front.sv]
// front end: takes frame bytes, captures header fields, emits one record per frame
module ithc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          link_type,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                frame_last,
	input  logic                q_full,
	output logic                push,
	output ithc_pkg::frame_rec_t rec
);
	import ithc_pkg::*;

	logic [6:0]  pos_q;
	logic [15:0] ether_type_q;
	logic [3:0]  ip_words_q;
	logic [15:0] total_len_q;
	logic [15:0] frag_word_q;
	logic [7:0]  proto_q;
	logic [3:0]  tcp_words_q;

	logic [15:0] et_n;
	logic [3:0]  iw_n;
	logic [15:0] tl_n;
	logic [15:0] fw_n;
	logic [7:0]  pr_n;
	logic [3:0]  tw_n;
	logic [4:0]  off_n;
	logic        is_eth;
	logic        in_ip;
	logic [6:0]  rel;
	logic [6:0]  tcp_rel;
	logic        accept;

	// a byte moves whenever the record queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && frame_last;
	assign is_eth   = (link_type == LINK_ETH);

	// ether type capture comes first, the offset follows from it
	always_comb begin
		et_n = ether_type_q;
		if (is_eth && pos_q == POS_ETYPE_HI) begin
			et_n[15:8] = data_byte;
		end
		if (is_eth && pos_q == POS_ETYPE_LO) begin
			et_n[7:0] = data_byte;
		end
		case (link_type)
			LINK_ETH:  off_n = (et_n == ETYPE_VLAN) ? OFF_VLAN : OFF_ETH;
			LINK_RAW:  off_n = OFF_RAW;
			LINK_NULL: off_n = OFF_NULL;
			LINK_SLL:  off_n = OFF_SLL;
			default:   off_n = OFF_SLL;
		endcase
	end

	// ip and tcp field capture at positions relative to the ip header
	assign in_ip   = !(is_eth && pos_q < {2'b00, OFF_ETH}) && (pos_q >= {2'b00, off_n});
	assign rel     = pos_q - {2'b00, off_n};
	assign tcp_rel = {1'b0, ip_words_q, 2'b00} + REL_TCP_DOFF;

	always_comb begin
		iw_n = ip_words_q;
		tl_n = total_len_q;
		fw_n = frag_word_q;
		pr_n = proto_q;
		tw_n = tcp_words_q;
		if (in_ip) begin
			case (rel)
				REL_IHL:     iw_n = data_byte[3:0];
				REL_TLEN_HI: tl_n[15:8] = data_byte;
				REL_TLEN_LO: tl_n[7:0] = data_byte;
				REL_FRAG_HI: fw_n[15:8] = data_byte;
				REL_FRAG_LO: fw_n[7:0] = data_byte;
				REL_PROTO:   pr_n = data_byte;
				default:     ;
			endcase
			if (rel == tcp_rel) begin
				tw_n = data_byte[7:4];
			end
		end
	end

	// record of the frame including its last byte
	always_comb begin
		rec.is_eth     = is_eth;
		rec.frame_len  = {1'b0, pos_q} + 8'd1;
		rec.link_off   = off_n;
		rec.ether_type = et_n;
		rec.ip_words   = iw_n;
		rec.total_len  = tl_n;
		rec.frag_word  = fw_n;
		rec.proto      = pr_n;
		rec.tcp_words  = tw_n;
	end

	// frame state, cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			ether_type_q <= '0;
			ip_words_q   <= '0;
			total_len_q  <= '0;
			frag_word_q  <= '0;
			proto_q      <= '0;
			tcp_words_q  <= '0;
		end else if (accept) begin
			if (frame_last) begin
				pos_q        <= '0;
				ether_type_q <= '0;
				ip_words_q   <= '0;
				total_len_q  <= '0;
				frag_word_q  <= '0;
				proto_q      <= '0;
				tcp_words_q  <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				ether_type_q <= et_n;
				ip_words_q   <= iw_n;
				total_len_q  <= tl_n;
				frag_word_q  <= fw_n;
				proto_q      <= pr_n;
				tcp_words_q  <= tw_n;
			end
		end
	end

`ifndef SYNTHESIS
	// position counts up by one per byte until saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !frame_last && pos_q != POS_MAX) |=> (pos_q == $past(pos_q) + 7'd1))
		else $error("byte position did not advance");

	// a frame's last byte restarts the position
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_last) |=> (pos_q == 7'd0 && ip_words_q == 4'd0))
		else $error("frame state not cleared after last byte");
`endif

endmodule

[rtl/ithc_queue.sv]
// short queue of frame records between the front and the back
module ithc_queue #(
	parameter int DEPTH = ithc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ithc_pkg::frame_rec_t wr_rec,
	input  logic                 pop,
	output ithc_pkg::frame_rec_t rd_rec,
	output logic                 full,
	output logic                 empty
);
	import ithc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frame_rec_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_rec = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// no write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full record queue");

	// no read from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty record queue");
`endif

endmodule

[rtl/ithc_back.sv]
// back end: turns a frame record into a verdict and holds it in the output register
module ithc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 pop,
	input  ithc_pkg::frame_rec_t rec,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           verdict,
	output logic [15:0]          transport_len,
	output logic [5:0]           ip_header_bytes,
	output logic [7:0]           protocol,
	output logic [4:0]           link_offset
);
	import ithc_pkg::*;

	logic        out_valid_q;
	logic [3:0]  verdict_q;
	logic [15:0] transport_len_q;
	logic [5:0]  hdr_bytes_q;
	logic [7:0]  protocol_q;
	logic [4:0]  link_off_q;

	logic [7:0]  len;
	logic [7:0]  off8;
	logic [5:0]  hdr6;
	logic [7:0]  hdr8;
	logic [4:0]  tcp_words_sum;
	logic [6:0]  tcp_hdr_bytes;
	logic [15:0] tcp_hdr16;
	logic [15:0] udp_need;
	logic [15:0] icmp_need;
	logic [15:0] hdr16;
	logic [7:0]  tcp_need;

	logic        short_eth;
	logic        non_ip;
	logic        trunc_frag;
	logic        fragment;
	logic        rsv_bit;
	logic        bad_ihl;
	logic        trunc_proto;
	logic        trunc_tcp;

	verdict_t    vd;
	logic [15:0] pay;
	logic [4:0]  off_o;

	// take a record whenever the output register is free or being drained
	assign pop = !q_empty && (!out_valid_q || !out_stall);

	// header sizes and length needs
	assign len           = rec.frame_len;
	assign off8          = {3'b000, rec.link_off};
	assign hdr6          = {rec.ip_words, 2'b00};
	assign hdr8          = {2'b00, hdr6};
	assign hdr16         = {10'd0, hdr6};
	assign tcp_words_sum = {1'b0, rec.ip_words} + {1'b0, rec.tcp_words};
	assign tcp_hdr_bytes = {tcp_words_sum, 2'b00};
	assign tcp_hdr16     = {9'd0, tcp_hdr_bytes};
	assign udp_need      = hdr16 + {8'd0, UDP_HDR_LEN};
	assign icmp_need     = hdr16 + {8'd0, ICMP_HDR_LEN};
	assign tcp_need      = off8 + hdr8 + 8'd13;

	// individual checks, all side by side
	assign short_eth   = rec.is_eth && (len < {3'b000, OFF_ETH});
	assign non_ip      = rec.is_eth && (rec.ether_type != ETYPE_IPV4)
		&& (rec.ether_type != ETYPE_VLAN);
	assign trunc_frag  = len < off8 + 8'd8;
	assign fragment    = (rec.frag_word != 16'd0) && !rec.frag_word[14];
	assign rsv_bit     = rec.frag_word[15];
	assign bad_ihl     = rec.ip_words < MIN_IHL;
	assign trunc_proto = len < off8 + 8'd10;
	assign trunc_tcp   = len < tcp_need;

	// checks in priority order
	always_comb begin
		vd    = V_OTHER_IP;
		pay   = '0;
		off_o = rec.link_off;
		if (short_eth) begin
			vd    = V_SHORT_ETH;
			off_o = '0;
		end else if (non_ip) begin
			vd    = V_NON_IP;
			off_o = '0;
		end else if (trunc_frag) begin
			vd = V_TRUNCATED;
		end else if (fragment) begin
			vd = V_FRAGMENT;
		end else if (rsv_bit) begin
			vd = V_RSV_BIT;
		end else if (bad_ihl) begin
			vd = V_BAD_IHL;
		end else if (trunc_proto) begin
			vd = V_TRUNCATED;
		end else if (rec.proto == PROTO_TCP) begin
			if (trunc_tcp) begin
				vd = V_TRUNCATED;
			end else if (rec.tcp_words < MIN_IHL) begin
				vd = V_BAD_TCP_OFF;
			end else if (tcp_hdr16 > rec.total_len) begin
				vd = V_TCP_LEN;
			end else begin
				vd  = V_TCP;
				pay = rec.total_len - tcp_hdr16;
			end
		end else if (rec.proto == PROTO_UDP) begin
			if (udp_need > rec.total_len) begin
				vd = V_UDP_LEN;
			end else begin
				vd  = V_UDP;
				pay = rec.total_len - udp_need;
			end
		end else if (rec.proto == PROTO_ICMP) begin
			if (icmp_need > rec.total_len) begin
				vd = V_ICMP_LEN;
			end else begin
				vd  = V_ICMP;
				pay = rec.total_len - icmp_need;
			end
		end else begin
			vd  = V_OTHER_IP;
			pay = rec.total_len - hdr16;
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q       <= vd;
			transport_len_q <= pay;
			hdr_bytes_q     <= hdr6;
			protocol_q      <= rec.proto;
			link_off_q      <= off_o;
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = verdict_q;
	assign transport_len   = transport_len_q;
	assign ip_header_bytes = hdr_bytes_q;
	assign protocol        = protocol_q;
	assign link_offset     = link_off_q;

`ifndef SYNTHESIS
	// payload length only for classified ip transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q > 4'(V_OTHER_IP)) |-> (transport_len_q == 16'd0))
		else $error("payload length set on an error verdict");

	// no link offset when the frame never reached ip
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (verdict_q == 4'(V_SHORT_ETH) || verdict_q == 4'(V_NON_IP)))
		|-> (link_off_q == 5'd0))
		else $error("link offset set on a non-ip verdict");
`endif

endmodule

[rtl/ipv4_transport_header_classifier_core.sv]
// top level of the ipv4 transport header classifier
// The block takes one frame byte per cycle and gives one verdict transaction for each byte
// flagged frame_last once accepted, via the record queue and output register. The front
// captures header fields as bytes arrive; on a frame's last byte it writes a record into a
// QUEUE_DEPTH-entry queue, which the user must keep at least 2 deep (the block does not
// enforce it); the back classifies one record per cycle whenever the output register is
// free or drained. Bytes are taken every cycle while the queue has room; in_stall rises
// only when the queue is full, which happens only if the output side stalls. link_type is
// written through cfg_wr_en/cfg_wr_data and must only change while no frame is in progress.
module ipv4_transport_header_classifier_core #(
	parameter int QUEUE_DEPTH = ithc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  verdict,
	output logic [15:0] transport_len,
	output logic [5:0]  ip_header_bytes,
	output logic [7:0]  protocol,
	output logic [4:0]  link_offset
);
	import ithc_pkg::*;

	logic [1:0] link_type_q;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	frame_rec_t wr_rec;
	frame_rec_t rd_rec;

	// link type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= LINK_ETH;
		end else if (cfg_wr_en) begin
			link_type_q <= cfg_wr_data;
		end
	end

	// byte capture
	ithc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.link_type  (link_type_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.q_full     (q_full),
		.push       (push),
		.rec        (wr_rec)
	);

	// record queue
	ithc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.full   (q_full),
		.empty  (q_empty)
	);

	// classification and output register
	ithc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.pop             (pop),
		.rec             (rd_rec),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.verdict         (verdict),
		.transport_len   (transport_len),
		.ip_header_bytes (ip_header_bytes),
		.protocol        (protocol),
		.link_offset     (link_offset)
	);

endmodule

[dv/tb_ipv4_transport_header_classifier_core.sv]
// testbench of the ipv4 transport header classifier core: directed and random frames checked
module tb_ipv4_transport_header_classifier_core;
	import ithc_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          LONG_HOLD    = 300;
	localparam logic [15:0] FRAG_DF      = 16'h4000;
	localparam logic [7:0]  PROTO_GRE    = 8'd47;

	// one verdict transaction as the block should give it
	typedef struct packed {
		verdict_t    v;
		logic [15:0] pay;
		logic [5:0]  hdr;
		logic [7:0]  proto;
		logic [4:0]  off;
	} verdict_rec_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        frame_last;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  verdict;
	logic [15:0] transport_len;
	logic [5:0]  ip_header_bytes;
	logic [7:0]  protocol;
	logic [4:0]  link_offset;

	// header capture state of the frame in progress
	logic [1:0]  link_sel;
	logic [6:0]  cur_pos;
	logic [15:0] cur_etype;
	logic [3:0]  cur_ihl;
	logic [15:0] cur_tlen;
	logic [15:0] cur_frag;
	logic [7:0]  cur_proto;
	logic [3:0]  cur_doff;

	verdict_rec_t pending_verdicts[$];
	logic [7:0]   frame_buf[$];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          fail_cnt = 0;
	int          bytes_sent = 0;
	int          verdicts_seen = 0;
	int unsigned cycle_count = 0;
	logic        hold_on = 1'b0;
	event        long_hold_ev;

	ipv4_transport_header_classifier_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.frame_last      (frame_last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.verdict         (verdict),
		.transport_len   (transport_len),
		.ip_header_bytes (ip_header_bytes),
		.protocol        (protocol),
		.link_offset     (link_offset)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stall: random idling, or a long hold when asked
	always @(negedge clk) begin
		out_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
	end

	// long receiver hold, counted here in cycles
	always begin
		@(long_hold_ev);
		hold_on = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on = 1'b0;
	end

	function automatic void clear_frame_state();
		cur_pos   = '0;
		cur_etype = '0;
		cur_ihl   = '0;
		cur_tlen  = '0;
		cur_frag  = '0;
		cur_proto = '0;
		cur_doff  = '0;
	endfunction

	// where the ip header begins for the current link type
	function automatic int ip_start();
		case (link_sel)
			LINK_ETH:  return (cur_etype == ETYPE_VLAN) ? int'(OFF_VLAN) : int'(OFF_ETH);
			LINK_RAW:  return int'(OFF_RAW);
			LINK_NULL: return int'(OFF_NULL);
			default:   return int'(OFF_SLL);
		endcase
	endfunction

	// capture header fields from the byte at the current position
	function automatic void capture_byte(input logic [7:0] b);
		int rel;
		if (link_sel == LINK_ETH && cur_pos == POS_ETYPE_HI) cur_etype[15:8] = b;
		if (link_sel == LINK_ETH && cur_pos == POS_ETYPE_LO) cur_etype[7:0] = b;
		if (link_sel == LINK_ETH && int'(cur_pos) < int'(OFF_ETH)) return;
		if (int'(cur_pos) < ip_start()) return;
		rel = int'(cur_pos) - ip_start();
		if (rel == REL_IHL) cur_ihl = b[3:0];
		else if (rel == REL_TLEN_HI) cur_tlen[15:8] = b;
		else if (rel == REL_TLEN_LO) cur_tlen[7:0] = b;
		else if (rel == REL_FRAG_HI) cur_frag[15:8] = b;
		else if (rel == REL_FRAG_LO) cur_frag[7:0] = b;
		else if (rel == REL_PROTO) cur_proto = b;
		if (rel == int'(cur_ihl) * 4 + int'(REL_TCP_DOFF)) cur_doff = b[7:4];
	endfunction

	// verdict of the frame whose last byte has just been captured
	function automatic verdict_rec_t judge_frame();
		verdict_rec_t r;
		int len, off, hdr, tcp_sum;
		len = int'(cur_pos) + 1;
		off = ip_start();
		hdr = int'(cur_ihl) * 4;
		tcp_sum = (int'(cur_ihl) + int'(cur_doff)) * 4;
		r.pay = '0;
		if (link_sel == LINK_ETH && len < int'(OFF_ETH)) begin
			r.v = V_SHORT_ETH;
			off = 0;
		end else if (link_sel == LINK_ETH && cur_etype != ETYPE_IPV4 && cur_etype != ETYPE_VLAN) begin
			r.v = V_NON_IP;
			off = 0;
		end else if (len < off + 8) begin
			r.v = V_TRUNCATED;
		end else if (cur_frag != 0 && !cur_frag[14]) begin
			// any bit of the flags and offset word set without don't-fragment
			r.v = V_FRAGMENT;
		end else if (cur_frag[15]) begin
			r.v = V_RSV_BIT;
		end else if (cur_ihl < MIN_IHL) begin
			r.v = V_BAD_IHL;
		end else if (len < off + 10) begin
			r.v = V_TRUNCATED;
		end else if (cur_proto == PROTO_TCP) begin
			if (len < off + hdr + 13) r.v = V_TRUNCATED;
			else if (cur_doff < MIN_IHL) r.v = V_BAD_TCP_OFF;
			else if (tcp_sum > int'(cur_tlen)) r.v = V_TCP_LEN;
			else begin
				r.v = V_TCP;
				r.pay = 16'(int'(cur_tlen) - tcp_sum);
			end
		end else if (cur_proto == PROTO_UDP) begin
			if (hdr + int'(UDP_HDR_LEN) > int'(cur_tlen)) r.v = V_UDP_LEN;
			else begin
				r.v = V_UDP;
				r.pay = 16'(int'(cur_tlen) - hdr - int'(UDP_HDR_LEN));
			end
		end else if (cur_proto == PROTO_ICMP) begin
			if (hdr + int'(ICMP_HDR_LEN) > int'(cur_tlen)) r.v = V_ICMP_LEN;
			else begin
				r.v = V_ICMP;
				r.pay = 16'(int'(cur_tlen) - hdr - int'(ICMP_HDR_LEN));
			end
		end else begin
			// other protocols wrap modulo 65536
			r.v = V_OTHER_IP;
			r.pay = 16'(int'(cur_tlen) - hdr);
		end
		r.hdr = 6'(hdr);
		r.proto = cur_proto;
		r.off = 5'(off);
		return r;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic last);
		capture_byte(b);
		if (!last) begin
			if (cur_pos < POS_MAX) cur_pos = cur_pos + 7'd1;
		end else begin
			pending_verdicts.push_back(judge_frame());
			clear_frame_state();
		end
	endfunction

	function automatic void check_field(input string fld, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", fld, want_v, got_v);
			fail_cnt++;
		end
	endfunction

	// compare each verdict transaction with the oldest expectation
	always @(posedge clk) begin : verdict_check
		verdict_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict transaction with none expected: verdict %0d", verdict);
				fail_cnt++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", want.v, verdict);
				check_field("transport_len", want.pay, transport_len);
				check_field("ip_header_bytes", want.hdr, ip_header_bytes);
				check_field("protocol", want.proto, protocol);
				check_field("link_offset", want.off, link_offset);
			end
			verdicts_seen++;
		end
	end

	// one byte transaction, with random sender idling ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		frame_last <= last;
		@(posedge clk);
		while (!(in_valid && !in_stall)) @(posedge clk);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// sender stops until every verdict has come back, then lets the block settle
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_link(input logic [1:0] lt);
		wait_for_results();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lt;
		@(posedge clk);
		link_sel = lt;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// frame of n bytes, random or all one value
	task automatic fill_bytes(input int n, input int fixed);
		frame_buf.delete();
		repeat (n) frame_buf.push_back((fixed < 0) ? 8'($urandom) : 8'(fixed));
	endtask

	task automatic trim_frame(input int n);
		while (frame_buf.size() > n) void'(frame_buf.pop_back());
	endtask

	// link header, ip header with options, transport header and payload
	task automatic make_frame(input int etype, input int ihl, input int tlen, input int fragw,
			input int proto, input int doff, input int pay);
		int ip_at;
		frame_buf.delete();
		case (link_sel)
			LINK_ETH: begin
				repeat (12) frame_buf.push_back(8'($urandom));
				frame_buf.push_back(8'(etype >> 8));
				frame_buf.push_back(8'(etype));
				if (etype == ETYPE_VLAN) begin
					repeat (2) frame_buf.push_back(8'($urandom));
					frame_buf.push_back(ETYPE_IPV4[15:8]);
					frame_buf.push_back(ETYPE_IPV4[7:0]);
				end
			end
			LINK_NULL: repeat (4) frame_buf.push_back(8'($urandom));
			LINK_SLL:  repeat (16) frame_buf.push_back(8'($urandom));
			default: ;
		endcase
		ip_at = frame_buf.size();
		frame_buf.push_back({4'h4, 4'(ihl)});
		repeat (5) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'(fragw >> 8));
		frame_buf.push_back(8'(fragw));
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'(proto));
		repeat (10) frame_buf.push_back(8'($urandom));
		repeat ((ihl > 5) ? (ihl - 5) * 4 : 0) frame_buf.push_back(8'($urandom));
		if (proto == PROTO_TCP) begin
			repeat (12) frame_buf.push_back(8'($urandom));
			frame_buf.push_back({4'(doff), 4'($urandom)});
			repeat (7 + ((doff > 5) ? (doff - 5) * 4 : 0)) frame_buf.push_back(8'($urandom));
		end else if (proto == PROTO_UDP || proto == PROTO_ICMP) begin
			repeat (8) frame_buf.push_back(8'($urandom));
		end
		repeat (pay) frame_buf.push_back(8'($urandom));
		if (tlen < 0) tlen = frame_buf.size() - ip_at;
		frame_buf[ip_at + 2] = 8'(tlen >> 8);
		frame_buf[ip_at + 3] = 8'(tlen);
	endtask

	// mostly well-formed frames with random content, some noise and some cut short
	task automatic make_random_frame();
		int pick, etype, ihl, proto, doff, fragw, tlen, pay;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			pick = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 40);
			fill_bytes(pick, -1);
			if (link_sel == LINK_ETH && frame_buf.size() > 13 && $urandom_range(0, 1) == 1) begin
				frame_buf[12] = ETYPE_IPV4[15:8];
				frame_buf[13] = ETYPE_IPV4[7:0];
			end
			return;
		end
		pick = $urandom_range(0, 9);
		etype = (pick < 7) ? ETYPE_IPV4 : (pick < 9) ? ETYPE_VLAN : $urandom_range(0, 16'hFFFF);
		pick = $urandom_range(0, 9);
		ihl = (pick < 8) ? 5 : (pick < 9) ? $urandom_range(6, 15) : $urandom_range(0, 4);
		pick = $urandom_range(0, 9);
		proto = (pick < 4) ? PROTO_TCP : (pick < 6) ? PROTO_UDP :
			(pick < 8) ? PROTO_ICMP : $urandom_range(0, 255);
		pick = $urandom_range(0, 19);
		doff = (pick < 17) ? $urandom_range(5, 6) : (pick < 18) ? $urandom_range(7, 15) :
			$urandom_range(0, 4);
		pick = $urandom_range(0, 9);
		fragw = (pick < 6) ? FRAG_DF : (pick < 8) ? 0 : $urandom_range(0, 16'hFFFF);
		pick = $urandom_range(0, 9);
		tlen = -1;
		if (pick == 8) tlen = $urandom_range(0, 80);
		if (pick == 9) tlen = $urandom_range(0, 16'hFFFF);
		pay = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
		make_frame(etype, ihl, tlen, fragw, proto, doff, pay);
		if ($urandom_range(0, 99) < 15) trim_frame($urandom_range(1, frame_buf.size() - 1));
	endtask

	// every verdict on ethernet framing, field extremes included
	task automatic test_directed_ethernet();
		set_link(LINK_ETH);
		send_idle_pct = 20;
		recv_idle_pct = 20;
		// too short for the type field, unknown type, all-ones and all-zeros bytes
		fill_bytes(13, -1);
		send_frame();
		make_frame(16'h86DD, 5, -1, FRAG_DF, PROTO_TCP, 5, 4);
		send_frame();
		fill_bytes(60, 255);
		send_frame();
		fill_bytes(30, 0);
		send_frame();
		// well-formed tcp, vlan-tagged udp, icmp with full options
		make_frame(ETYPE_IPV4, 5, -1, FRAG_DF, PROTO_TCP, 5, 6);
		send_frame();
		make_frame(ETYPE_VLAN, 5, -1, 0, PROTO_UDP, 5, 3);
		send_frame();
		make_frame(ETYPE_IPV4, 15, -1, FRAG_DF, PROTO_ICMP, 5, 0);
		send_frame();
		// other protocol with total length below the header wraps round, then one with maximum fields
		make_frame(ETYPE_IPV4, 5, 0, FRAG_DF, PROTO_GRE, 5, 2);
		send_frame();
		make_frame(ETYPE_IPV4, 15, 16'hFFFF, FRAG_DF, 255, 15, 0);
		send_frame();
		// cut within the fragment word, before the protocol, before the tcp data offset
		make_frame(ETYPE_IPV4, 5, -1, FRAG_DF, PROTO_TCP, 5, 0);
		trim_frame(21);
		send_frame();
		make_frame(ETYPE_IPV4, 5, -1, FRAG_DF, PROTO_TCP, 5, 0);
		trim_frame(23);
		send_frame();
		make_frame(ETYPE_IPV4, 5, -1, FRAG_DF, PROTO_TCP, 5, 0);
		trim_frame(46);
		send_frame();
		// fragment, reserved bit, short ip header
		make_frame(ETYPE_IPV4, 5, -1, 16'h2000, PROTO_TCP, 5, 0);
		send_frame();
		make_frame(ETYPE_IPV4, 5, -1, 16'hC000, PROTO_TCP, 5, 0);
		send_frame();
		make_frame(ETYPE_IPV4, 4, -1, FRAG_DF, PROTO_UDP, 5, 0);
		send_frame();
		// tcp data offset too small, then lengths too small for each transport
		make_frame(ETYPE_IPV4, 5, -1, FRAG_DF, PROTO_TCP, 4, 0);
		send_frame();
		make_frame(ETYPE_IPV4, 5, 39, FRAG_DF, PROTO_TCP, 5, 0);
		send_frame();
		make_frame(ETYPE_IPV4, 5, 27, FRAG_DF, PROTO_UDP, 5, 0);
		send_frame();
		make_frame(ETYPE_IPV4, 5, 27, 0, PROTO_ICMP, 5, 0);
		send_frame();
		// frame running past the saturating byte position
		make_frame(ETYPE_IPV4, 5, -1, FRAG_DF, PROTO_TCP, 5, 120);
		send_frame();
	endtask

	// fixed offsets of raw, null and cooked captures
	task automatic test_link_types();
		set_link(LINK_RAW);
		make_frame(0, 5, -1, FRAG_DF, PROTO_TCP, 5, 2);
		send_frame();
		fill_bytes(1, -1);
		send_frame();
		set_link(LINK_NULL);
		make_frame(0, 5, -1, 0, PROTO_UDP, 5, 1);
		send_frame();
		set_link(LINK_SLL);
		make_frame(0, 6, -1, FRAG_DF, PROTO_ICMP, 5, 4);
		send_frame();
		make_frame(0, 5, -1, FRAG_DF, PROTO_TCP, 5, 0);
		trim_frame(20);
		send_frame();
	endtask

	// receiver holds off while short frames keep coming, so the block stalls its input
	task automatic test_backpressure();
		int k;
		set_link(LINK_RAW);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> long_hold_ev;
		for (k = 0; k < 40; k++) begin
			fill_bytes(1 + k % 3, -1);
			send_frame();
		end
		wait_for_results();
	endtask

	// random frames; each link change first drains every outstanding verdict
	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int byte_goal,
			input int verdict_goal);
		int b0, v0, nfr;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		b0 = bytes_sent;
		v0 = verdicts_seen;
		nfr = 0;
		while (bytes_sent - b0 < byte_goal || verdicts_seen - v0 < verdict_goal) begin
			if (nfr % 8 == 0) set_link(2'($urandom_range(0, 3)));
			make_random_frame();
			send_frame();
			nfr++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = LINK_ETH;
		in_valid = 1'b0;
		data_byte = '0;
		frame_last = 1'b0;
		link_sel = LINK_ETH;
		clear_frame_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_ethernet();
		test_link_types();
		test_backpressure();
		test_random_traffic(12, 76, 60, 1);
		test_random_traffic(76, 12, 60, 1);
		test_random_traffic(0, 0, 60, 1);
		wait_for_results();

		if (pending_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", pending_verdicts.size());
			fail_cnt++;
		end
		$display("run covered %0d frame bytes and %0d verdict transactions", bytes_sent,
			verdicts_seen);
		$display("over all link types, directed cases, a long receiver hold and three idling mixes");
		if (fail_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/ithc_pkg.sv
rtl/ithc_front.sv
rtl/ithc_queue.sv
rtl/ithc_back.sv
rtl/ipv4_transport_header_classifier_core.sv
dv/tb_ipv4_transport_header_classifier_core.sv
